// ===== sv/xtea_encrypt_with_signature_check_top_macros.svh =====
// assertion macros for the xtea block with signature check
// used by the top level only; expects clk and rst_n in scope
`ifndef XTEA_ENCRYPT_WITH_SIGNATURE_CHECK_TOP_MACROS_SVH
`define XTEA_ENCRYPT_WITH_SIGNATURE_CHECK_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define XESC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/xesc_pkg.sv =====
// shared types, constants and the round mixing function of the xtea block
// no dependencies

package xesc_pkg;

  localparam int WORD_W          = 32;
  localparam int KEY_CNT         = 4;
  localparam int KEY_IDX_W       = 2;
  localparam int ROUND_COUNT_DEF = 32;
  localparam int CHECK_ROUND     = 8;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  // key register values after reset
  localparam logic [WORD_W-1:0] KEY_RESET [KEY_CNT] = '{
    32'h0011_2233, 32'h4455_6677, 32'h8899_AABB, 32'hCCDD_EEFF
  };

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the item, clear sum and flag
    logic step;      // run one round
    logic set_fail;  // flag a signature mismatch
    logic emit;      // move the words into the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mismatch;  // round result differs from the signatures
  } status_t;

  // shift-xor-add mix of one word
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w);
    mix = ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

// ===== sv/xesc_if.sv =====
// valid/ready channel interfaces for items in and results out
// depends on xesc_pkg

interface xesc_in_if import xesc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] first_word;
  logic [WORD_W-1:0] second_word;
  logic [WORD_W-1:0] first_signature;
  logic [WORD_W-1:0] second_signature;

  modport source (output valid, first_word, second_word, first_signature,
                  second_signature, input ready);
  modport sink (input valid, first_word, second_word, first_signature,
                second_signature, output ready);
endinterface

interface xesc_out_if import xesc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_first_word;
  logic [WORD_W-1:0] out_second_word;
  logic              signature_failed;

  modport source (output valid, out_first_word, out_second_word, signature_failed,
                  input ready);
  modport sink (input valid, out_first_word, out_second_word, signature_failed,
                output ready);
endinterface

// ===== sv/xesc_dp.sv =====
// datapath: key registers, round unit, signature compare and result register
// depends on xesc_pkg

module xesc_dp import xesc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [WORD_W-1:0]    in_first_word,
  input  logic [WORD_W-1:0]    in_second_word,
  input  logic [WORD_W-1:0]    in_first_signature,
  input  logic [WORD_W-1:0]    in_second_signature,
  input  cmd_t                 cmd,
  output status_t              st,
  output logic [WORD_W-1:0]    res_first_word,
  output logic [WORD_W-1:0]    res_second_word,
  output logic                 res_failed
);

  logic [WORD_W-1:0] key_r [KEY_CNT];
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] sum_r, sum_nxt;
  logic [WORD_W-1:0] sig_a_r, sig_a_nxt;
  logic [WORD_W-1:0] sig_b_r, sig_b_nxt;
  logic              fail_r, fail_nxt;
  logic [WORD_W-1:0] res_a_r, res_a_nxt;
  logic [WORD_W-1:0] res_b_r, res_b_nxt;
  logic              res_fail_r, res_fail_nxt;
  logic [WORD_W-1:0] a_rnd, b_rnd, sum_rnd;

  // key registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_CNT; i++) key_r[i] <= KEY_RESET[i];
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  // one full encipher round
  always_comb begin
    sum_rnd = sum_r + XTEA_DELTA;
    a_rnd   = a_r + (mix(b_r) ^ (sum_r + key_r[sum_r[KEY_IDX_W-1:0]]));
    b_rnd   = b_r + (mix(a_rnd) ^ (sum_rnd + key_r[sum_rnd[12:11]]));
  end

  assign st.mismatch = (a_rnd != sig_a_r) || (b_rnd != sig_b_r);

  // working words, signatures, sum and flag
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    sum_nxt   = sum_r;
    sig_a_nxt = sig_a_r;
    sig_b_nxt = sig_b_r;
    fail_nxt  = fail_r;
    if (cmd.load) begin
      a_nxt     = in_first_word;
      b_nxt     = in_second_word;
      sig_a_nxt = in_first_signature;
      sig_b_nxt = in_second_signature;
      sum_nxt   = '0;
      fail_nxt  = 1'b0;
    end else if (cmd.step) begin
      a_nxt   = a_rnd;
      b_nxt   = b_rnd;
      sum_nxt = sum_rnd;
      if (cmd.set_fail) fail_nxt = 1'b1;
    end
  end

  // result register
  always_comb begin
    res_a_nxt    = res_a_r;
    res_b_nxt    = res_b_r;
    res_fail_nxt = res_fail_r;
    if (cmd.emit) begin
      res_a_nxt    = a_r;
      res_b_nxt    = b_r;
      res_fail_nxt = fail_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    sum_r      <= sum_nxt;
    sig_a_r    <= sig_a_nxt;
    sig_b_r    <= sig_b_nxt;
    fail_r     <= fail_nxt;
    res_a_r    <= res_a_nxt;
    res_b_r    <= res_b_nxt;
    res_fail_r <= res_fail_nxt;
  end

  assign res_first_word  = res_a_r;
  assign res_second_word = res_b_r;
  assign res_failed      = res_fail_r;

endmodule

// ===== sv/xesc_ctrl.sv =====
// controller: item handshake, round counter, early stop and result valid
// depends on xesc_pkg

module xesc_ctrl import xesc_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam int CNT_W = $clog2(ROUND_COUNT);
  localparam logic [CNT_W-1:0] LAST_RND  = CNT_W'(ROUND_COUNT - 1);
  localparam logic [CNT_W-1:0] CHECK_RND = CNT_W'(CHECK_ROUND - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // sequencing
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CHECK_RND && st.mismatch) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_FIN;
        end else if (cnt_r == LAST_RND) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid, held until taken
  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/xtea_encrypt_with_signature_check_top.sv =====
// xtea encipher with an early signature check after the eighth round
// in_ch takes one item: two block words and two signature words.
// out_ch gives one item per input: both words and the signature_failed flag.
// cfg_we/cfg_index/cfg_data write the four key words, index 0 to 3; the user
// must write them only while the block is idle, which the block does not
// enforce; reset loads the default key.
// one round is done per cycle by a single round unit; an item runs all
// ROUND_COUNT rounds (32 by default), or stops after round eight when the
// round-eight words do not match the signatures.
// one item is worked at a time: in_ch.ready is high only while the block is
// idle, so no new item is taken until the last one has been moved into the
// output register.
// the result sits in an output register; a new item may be taken while it
// waits. if the receiver stalls, the next finished item waits in the round
// unit until the register frees, and no new item is taken meanwhile.
// synchronous reset drops out_ch.valid and returns the block to idle.
// depends on xesc_pkg, xesc_if, xesc_ctrl, xesc_dp and the macros header

`include "xtea_encrypt_with_signature_check_top_macros.svh"

module xtea_encrypt_with_signature_check_top import xesc_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  xesc_in_if.sink              in_ch,
  xesc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t st;

  // sequencing
  xesc_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // rounds, keys and result register
  xesc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_first_word       (in_ch.first_word),
    .in_second_word      (in_ch.second_word),
    .in_first_signature  (in_ch.first_signature),
    .in_second_signature (in_ch.second_signature),
    .cmd                 (cmd),
    .st                  (st),
    .res_first_word      (out_ch.out_first_word),
    .res_second_word     (out_ch.out_second_word),
    .res_failed          (out_ch.signature_failed)
  );

  // checks
  `XESC_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "double accept")
  `XESC_ASSERT_SAME(a_emit_no_overwrite, cmd.emit, !out_ch.valid || out_ch.ready, "lost result")
  `XESC_ASSERT_SAME(a_fail_only_on_round, cmd.set_fail, cmd.step && st.mismatch, "stray fail flag")

endmodule

// ===== dv/xtea_encrypt_with_signature_check_top_tb.sv =====
// self-checking bench for the xtea encipher block with its round-eight signature check
// depends on xesc_pkg, xesc_if and xtea_encrypt_with_signature_check_top
// a local round model predicts every result; directed blocks come first, then random ones

module xtea_encrypt_with_signature_check_top_tb;
  import xesc_pkg::*;

  localparam int ROUND_CNT = ROUND_COUNT_DEF;

  typedef logic [WORD_W-1:0] word_t;

  // one block with its signatures, as offered on the input channel
  typedef struct {
    word_t first_word;
    word_t second_word;
    word_t first_sig;
    word_t second_sig;
  } block_item_t;

  // enciphered words and the check outcome
  typedef struct {
    word_t first_word;
    word_t second_word;
    logic  sig_failed;
  } cipher_item_t;

  // running state of the cipher between rounds
  typedef struct {
    word_t a;
    word_t b;
    word_t sum;
  } round_state_t;

  // how the signatures of a generated block relate to its eighth-round words
  typedef enum int {SIG_MATCH, SIG_BAD_FIRST, SIG_BAD_SECOND, SIG_RANDOM} sig_mode_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  logic  [KEY_IDX_W-1:0] cfg_index;
  word_t cfg_data;

  xesc_in_if  in_if ();
  xesc_out_if out_if ();

  xtea_encrypt_with_signature_check_top #(.ROUND_COUNT(ROUND_CNT)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  word_t        key_regs [KEY_CNT];
  block_item_t  pending_blocks [$];
  cipher_item_t expected_ciphers [$];
  int           fault_count = 0;
  int           idle_pct = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  logic         in_fire = 1'b0;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one xtea encipher round on the local key copy
  function automatic round_state_t xtea_round(round_state_t s);
    s.a   = s.a + ((((s.b << 4) ^ (s.b >> 5)) + s.b) ^ (s.sum + key_regs[s.sum[1:0]]));
    s.sum = s.sum + XTEA_DELTA;
    s.b   = s.b + ((((s.a << 4) ^ (s.a >> 5)) + s.a) ^ (s.sum + key_regs[s.sum[12:11]]));
    return s;
  endfunction

  // words as they stand when the signature check is made
  function automatic round_state_t check_round_words(word_t a, word_t b);
    round_state_t s;
    s.a   = a;
    s.b   = b;
    s.sum = '0;
    for (int n = 0; n < CHECK_ROUND; n++) s = xtea_round(s);
    return s;
  endfunction

  // expected result of one block: stop at the check round on a mismatch
  function automatic cipher_item_t encipher_checked(block_item_t blk);
    round_state_t s;
    cipher_item_t r;
    s.a   = blk.first_word;
    s.b   = blk.second_word;
    s.sum = '0;
    r.sig_failed = 1'b0;
    for (int n = 1; n <= ROUND_CNT && !r.sig_failed; n++) begin
      s = xtea_round(s);
      if (n == CHECK_ROUND && (s.a != blk.first_sig || s.b != blk.second_sig))
        r.sig_failed = 1'b1;
    end
    r.first_word  = s.a;
    r.second_word = s.b;
    return r;
  endfunction

  // build a block whose signatures match or miss by one bit, or are random
  function automatic block_item_t make_block(word_t a, word_t b, sig_mode_t mode);
    block_item_t  blk;
    round_state_t s;
    s = check_round_words(a, b);
    blk.first_word  = a;
    blk.second_word = b;
    blk.first_sig   = s.a;
    blk.second_sig  = s.b;
    case (mode)
      SIG_BAD_FIRST:  blk.first_sig  = s.a ^ (word_t'(1) << $urandom_range(WORD_W-1, 0));
      SIG_BAD_SECOND: blk.second_sig = s.b ^ (word_t'(1) << $urandom_range(WORD_W-1, 0));
      SIG_RANDOM: begin
        blk.first_sig  = $urandom;
        blk.second_sig = $urandom;
      end
      default: ;
    endcase
    return blk;
  endfunction

  // mostly random words, with the extremes now and then
  function automatic word_t rand_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return $urandom;
  endfunction

  // input driver: hold an item until taken, with random idle bursts
  always @(negedge clk) begin
    block_item_t nxt;
    if (in_if.valid && !in_fire) begin
      // item still on offer
    end else if (in_gap > 0) begin
      in_gap = in_gap - 1;
      in_if.valid <= 1'b0;
    end else if (rst_n && pending_blocks.size() != 0) begin
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        in_gap = $urandom_range(4, 0);
        in_if.valid <= 1'b0;
      end else begin
        nxt = pending_blocks.pop_front();
        in_if.valid            <= 1'b1;
        in_if.first_word       <= nxt.first_word;
        in_if.second_word      <= nxt.second_word;
        in_if.first_signature  <= nxt.first_sig;
        in_if.second_signature <= nxt.second_sig;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result receiver: random stall bursts on ready
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_if.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      out_gap = $urandom_range(4, 0);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // input monitor: predict the result of every accepted item
  always @(posedge clk) begin
    block_item_t blk;
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      blk.first_word  = in_if.first_word;
      blk.second_word = in_if.second_word;
      blk.first_sig   = in_if.first_signature;
      blk.second_sig  = in_if.second_signature;
      expected_ciphers.push_back(encipher_checked(blk));
    end
  end

  // output monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    cipher_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_ciphers.size() == 0) begin
        fault_count++;
        $display("%0t unexpected result: first %h second %h failed %b", $time,
                 out_if.out_first_word, out_if.out_second_word, out_if.signature_failed);
      end else begin
        want = expected_ciphers.pop_front();
        if (out_if.out_first_word !== want.first_word) begin
          fault_count++;
          $display("%0t out_first_word mismatch: expected %h actual %h", $time,
                   want.first_word, out_if.out_first_word);
        end
        if (out_if.out_second_word !== want.second_word) begin
          fault_count++;
          $display("%0t out_second_word mismatch: expected %h actual %h", $time,
                   want.second_word, out_if.out_second_word);
        end
        if (out_if.signature_failed !== want.sig_failed) begin
          fault_count++;
          $display("%0t signature_failed mismatch: expected %b actual %b", $time,
                   want.sig_failed, out_if.signature_failed);
        end
      end
    end
  end

  // wait at falling edges until every item is taken and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_blocks.size() != 0 || in_if.valid || expected_ciphers.size() != 0)
      @(negedge clk);
  endtask

  // write all four key words, one per cycle, while the block is idle
  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    word_t vals [KEY_CNT];
    vals = '{k0, k1, k2, k3};
    for (int i = 0; i < KEY_CNT; i++) begin
      cfg_we      <= 1'b1;
      cfg_index   <= i[KEY_IDX_W-1:0];
      cfg_data    <= vals[i];
      key_regs[i] = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // queue random blocks, most of them with matching signatures
  task automatic queue_random(int count);
    int        pick;
    sig_mode_t mode;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) mode = SIG_MATCH;
      else if (pick < 70) mode = SIG_BAD_FIRST;
      else if (pick < 85) mode = SIG_BAD_SECOND;
      else mode = SIG_RANDOM;
      pending_blocks.push_back(make_block(rand_word(), rand_word(), mode));
    end
  endtask

  // stimulus sequence
  initial begin
    block_item_t blk;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    in_if.valid            = 1'b0;
    in_if.first_word       = '0;
    in_if.second_word      = '0;
    in_if.first_signature  = '0;
    in_if.second_signature = '0;
    out_if.ready           = 1'b0;
    for (int i = 0; i < KEY_CNT; i++) key_regs[i] = KEY_RESET[i];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed blocks on the reset key
    idle_pct = 25;
    pending_blocks.push_back(make_block('0, '0, SIG_MATCH));
    pending_blocks.push_back(make_block('1, '1, SIG_MATCH));
    pending_blocks.push_back(make_block(32'h8000_0000, 32'h0000_0001, SIG_MATCH));
    pending_blocks.push_back(make_block(32'h0000_0001, 32'h8000_0000, SIG_MATCH));
    pending_blocks.push_back(make_block('0, '1, SIG_BAD_FIRST));
    pending_blocks.push_back(make_block('1, '0, SIG_BAD_SECOND));
    pending_blocks.push_back(make_block($urandom, $urandom, SIG_RANDOM));
    blk = make_block('0, '0, SIG_MATCH);
    blk.first_sig  = '0;
    blk.second_sig = '0;
    pending_blocks.push_back(blk);
    blk = make_block('1, '1, SIG_MATCH);
    blk.first_sig  = '1;
    blk.second_sig = '1;
    pending_blocks.push_back(blk);
    // one miss in the top bit of the first signature and one in the bottom bit of the second
    blk = make_block($urandom, $urandom, SIG_MATCH);
    blk.first_sig[WORD_W-1] = ~blk.first_sig[WORD_W-1];
    pending_blocks.push_back(blk);
    blk = make_block($urandom, $urandom, SIG_MATCH);
    blk.second_sig[0] = ~blk.second_sig[0];
    pending_blocks.push_back(blk);
    for (int n = 0; n < 3; n++) pending_blocks.push_back(make_block($urandom, $urandom, SIG_MATCH));
    drain();

    // all-zero key, including a few extremes
    load_key('0, '0, '0, '0);
    pending_blocks.push_back(make_block('0, '0, SIG_MATCH));
    pending_blocks.push_back(make_block('1, '1, SIG_MATCH));
    pending_blocks.push_back(make_block('1, '0, SIG_BAD_FIRST));
    queue_random(150);
    drain();

    // all-ones key
    idle_pct = 40;
    load_key('1, '1, '1, '1);
    pending_blocks.push_back(make_block('0, '0, SIG_MATCH));
    pending_blocks.push_back(make_block('1, '1, SIG_BAD_SECOND));
    queue_random(150);
    drain();

    // random key, heavy idling on both sides
    idle_pct = 50;
    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(300);
    drain();

    // random key, no idling at all
    idle_pct = 0;
    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(300);
    drain();

    // random key, light idling, then a quiet tail
    idle_pct = 20;
    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(400);
    while (pending_blocks.size() > 150) @(negedge clk);
    idle_pct = 0;
    queue_random(150);
    drain();

    // let any stray result show up before the verdict
    repeat (60) @(negedge clk);
    if (fault_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
